>>> hw/rtl/lew_pkg.sv
// Shared types and constants for the line editor with word wrap.
package lew_pkg;

	// Width of the cursor, scan pointers and erase counts.
	localparam int unsigned CW = 6;

	// Key codes that the editor treats specially.
	localparam logic [7:0] KEY_EOF    = 8'd4;
	localparam logic [7:0] KEY_BS     = 8'd8;
	localparam logic [7:0] KEY_KILL   = 8'd21;
	localparam logic [7:0] KEY_WERASE = 8'd23;
	localparam logic [7:0] KEY_DEL    = 8'd127;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TILDE   = 8'h7E;

	// Display action codes carried in each output beat.
	typedef enum logic [2:0] {
		ACT_ECHO    = 3'd0,
		ACT_ERASE   = 3'd1,
		ACT_BELL    = 3'd2,
		ACT_NEWLINE = 3'd3,
		ACT_END     = 3'd4
	} act_t;

	// Class of the latched keystroke.
	typedef enum logic [2:0] {
		KC_EOF,
		KC_WERASE,
		KC_ERASE,
		KC_KILL,
		KC_PRINT,
		KC_OTHER
	} key_cls_t;

	// Source of the character field of an emitted beat.
	typedef enum logic [1:0] {
		CHS_ZERO,
		CHS_KEY,
		CHS_MEM
	} ch_sel_t;

	// Source of the erase count field of an emitted beat.
	typedef enum logic [2:0] {
		CNT_ZERO,
		CNT_ONE,
		CNT_CUR,
		CNT_CUR_POS,
		CNT_WLEN
	} cnt_sel_t;

	// Scan pointer updates.
	typedef enum logic [2:0] {
		POS_HOLD,
		POS_CUR,
		POS_FULL,
		POS_DEC,
		POS_INC
	} pos_op_t;

	// Cursor updates.
	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_POS,
		CUR_DEC,
		CUR_CLR,
		CUR_IDX,
		CUR_INC
	} cur_op_t;

	// Line store read address select.
	typedef enum logic {
		RD_PREV,
		RD_POS
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_key;
		logic     emit;
		act_t     act;
		ch_sel_t  ch_sel;
		cnt_sel_t cnt_sel;
		logic     last;
		pos_op_t  pos_op;
		cur_op_t  cur_op;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_copy;
		logic     wr_key;
	} lew_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		key_cls_t key_cls;
		logic     cur_zero;
		logic     cur_full;
		logic     pos_zero;
		logic     pos_full;
		logic     rd_space;
		logic     out_free;
	} lew_sts_t;

endpackage

>>> hw/rtl/lew_dp.sv
// Datapath of the line editor: line store, cursor, scan pointers and output register.
module lew_dp
	import lew_pkg::*;
#(
	parameter int unsigned LINE_LEN = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lew_cmd_t    cmd,
	output lew_sts_t    sts,
	input  logic [7:0]  key_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_act,
	output logic [7:0]  out_char,
	output logic [CW-1:0] out_cnt,
	output logic        out_last
);

	localparam int unsigned AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
	localparam logic [CW-1:0] LEN_C = CW'(LINE_LEN);

	logic [7:0]    line_mem [LINE_LEN];
	logic [7:0]    key_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    rd_data_q;
	logic          out_valid_q;
	logic [2:0]    out_act_q;
	logic [7:0]    out_char_q;
	logic [CW-1:0] out_cnt_q;
	logic          out_last_q;

	logic [CW-1:0] pos_m1;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          wr_en;
	logic [7:0]    ch_nxt;
	logic [CW-1:0] cnt_nxt;
	key_cls_t      key_cls;

	// Classify the latched keystroke.
	always_comb begin
		unique case (key_q) inside
			KEY_EOF:             key_cls = KC_EOF;
			KEY_WERASE:          key_cls = KC_WERASE;
			KEY_BS, KEY_DEL:     key_cls = KC_ERASE;
			KEY_KILL:            key_cls = KC_KILL;
			[CH_SPACE:CH_TILDE]: key_cls = KC_PRINT;
			default:             key_cls = KC_OTHER;
		endcase
	end

	// Line store addressing: scans read the character before the pointer,
	// the word copy reads at the pointer and writes at the copy index.
	assign pos_m1  = pos_q - CW'(1);
	assign rd_addr = (cmd.rd_sel == RD_PREV) ? pos_m1[AW-1:0] : pos_q[AW-1:0];
	assign wr_addr = cmd.wr_copy ? idx_q[AW-1:0] : cursor_q[AW-1:0];
	assign wr_data = cmd.wr_copy ? rd_data_q : key_q;
	assign wr_en   = cmd.wr_copy | cmd.wr_key;

	// Line store with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= line_mem[rd_addr];
		end
	end

	// Keystroke holding register.
	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= key_in;
		end
	end

	// Cursor, scan pointer and copy index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
		end else begin
			case (cmd.cur_op)
				CUR_POS: cursor_q <= pos_q;
				CUR_DEC: cursor_q <= cursor_q - CW'(1);
				CUR_CLR: cursor_q <= '0;
				CUR_IDX: cursor_q <= idx_q;
				CUR_INC: cursor_q <= cursor_q + CW'(1);
				default: cursor_q <= cursor_q;
			endcase
			case (cmd.pos_op)
				POS_CUR:  pos_q <= cursor_q;
				POS_FULL: pos_q <= LEN_C;
				POS_DEC:  pos_q <= pos_m1;
				POS_INC:  pos_q <= pos_q + CW'(1);
				default:  pos_q <= pos_q;
			endcase
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// Field selection for the next output beat.
	always_comb begin
		case (cmd.ch_sel)
			CHS_KEY: ch_nxt = key_q;
			CHS_MEM: ch_nxt = rd_data_q;
			default: ch_nxt = '0;
		endcase
		case (cmd.cnt_sel)
			CNT_ONE:     cnt_nxt = CW'(1);
			CNT_CUR:     cnt_nxt = cursor_q;
			CNT_CUR_POS: cnt_nxt = cursor_q - pos_q;
			CNT_WLEN:    cnt_nxt = LEN_C - pos_q;
			default:     cnt_nxt = '0;
		endcase
	end

	// Output register; it frees up in the same cycle its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_act_q  <= cmd.act;
			out_char_q <= ch_nxt;
			out_cnt_q  <= cnt_nxt;
			out_last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_act   = out_act_q;
	assign out_char  = out_char_q;
	assign out_cnt   = out_cnt_q;
	assign out_last  = out_last_q;

	// Status back to the controller.
	assign sts.key_cls  = key_cls;
	assign sts.cur_zero = (cursor_q == '0);
	assign sts.cur_full = (cursor_q == LEN_C);
	assign sts.pos_zero = (pos_q == '0);
	assign sts.pos_full = (pos_q == LEN_C);
	assign sts.rd_space = (rd_data_q == CH_SPACE);
	assign sts.out_free = !out_valid_q || out_ready;

`ifndef ASSERT_OFF
	// The cursor never passes the end of the line.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= LEN_C)
		else $error("cursor beyond line length");

	// A beat is only loaded when the output register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("output beat overwritten");

	// A new character is only stored into a line that has room.
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_key |-> (cursor_q < LEN_C))
		else $error("append into full line");

	// The word copy always writes below the position it reads from.
	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_copy |-> (idx_q < pos_q))
		else $error("word copy overlaps its source");
`endif

endmodule

>>> hw/rtl/lew_ctrl.sv
// Controller state machine of the line editor: sequences scans, copies and emitted beats.
module lew_ctrl
	import lew_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lew_sts_t sts,
	output lew_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_BELL,
		S_END,
		S_BS,
		S_KILL,
		S_APPEND,
		S_WS_RD,
		S_WS_CHK,
		S_WW_RD,
		S_WW_CHK,
		S_WERASE_OUT,
		S_FULL_RD,
		S_FULL_CHK,
		S_WRAP_ERASE,
		S_WRAP_NL,
		S_COPY_RD,
		S_COPY_WR
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_key = 1'b1;
					state_nxt    = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.key_cls)
					KC_EOF:    state_nxt = sts.cur_zero ? S_END : S_BELL;
					KC_KILL:   state_nxt = sts.cur_zero ? S_BELL : S_KILL;
					KC_ERASE:  state_nxt = sts.cur_zero ? S_BELL : S_BS;
					KC_WERASE: begin
						if (sts.cur_zero) begin
							state_nxt = S_BELL;
						end else begin
							cmd.pos_op = POS_CUR;
							state_nxt  = S_WS_RD;
						end
					end
					KC_PRINT: begin
						if (sts.cur_full) begin
							cmd.pos_op = POS_FULL;
							state_nxt  = S_FULL_RD;
						end else begin
							state_nxt = S_APPEND;
						end
					end
					default: state_nxt = S_BELL;
				endcase
			end
			S_BELL: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.act   = ACT_BELL;
					cmd.last  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.act   = ACT_END;
					cmd.last  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_BS: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_ERASE;
					cmd.cnt_sel = CNT_ONE;
					cmd.last    = 1'b1;
					cmd.cur_op  = CUR_DEC;
					state_nxt   = S_IDLE;
				end
			end
			S_KILL: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_ERASE;
					cmd.cnt_sel = CNT_CUR;
					cmd.last    = 1'b1;
					cmd.cur_op  = CUR_CLR;
					state_nxt   = S_IDLE;
				end
			end
			S_APPEND: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.act    = ACT_ECHO;
					cmd.ch_sel = CHS_KEY;
					cmd.last   = 1'b1;
					cmd.wr_key = 1'b1;
					cmd.cur_op = CUR_INC;
					state_nxt  = S_IDLE;
				end
			end
			// Word delete: step back over trailing spaces.
			S_WS_RD: begin
				if (sts.pos_zero) begin
					state_nxt = S_WERASE_OUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_nxt  = S_WS_CHK;
				end
			end
			S_WS_CHK: begin
				if (sts.rd_space) begin
					cmd.pos_op = POS_DEC;
					state_nxt  = S_WS_RD;
				end else begin
					state_nxt = S_WW_CHK;
				end
			end
			// Word delete: step back over the word itself.
			S_WW_RD: begin
				if (sts.pos_zero) begin
					state_nxt = S_WERASE_OUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_nxt  = S_WW_CHK;
				end
			end
			S_WW_CHK: begin
				if (sts.rd_space) begin
					state_nxt = S_WERASE_OUT;
				end else begin
					cmd.pos_op = POS_DEC;
					state_nxt  = S_WW_RD;
				end
			end
			S_WERASE_OUT: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_ERASE;
					cmd.cnt_sel = CNT_CUR_POS;
					cmd.last    = 1'b1;
					cmd.cur_op  = CUR_POS;
					state_nxt   = S_IDLE;
				end
			end
			// Full line: search back for the space before the last word.
			S_FULL_RD: begin
				if (sts.pos_zero) begin
					state_nxt = S_BELL;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_nxt  = S_FULL_CHK;
				end
			end
			S_FULL_CHK: begin
				if (sts.rd_space) begin
					state_nxt = S_WRAP_ERASE;
				end else begin
					cmd.pos_op = POS_DEC;
					state_nxt  = S_FULL_RD;
				end
			end
			// Erase the partial word from the display unless it is empty.
			S_WRAP_ERASE: begin
				if (sts.pos_full) begin
					state_nxt = S_WRAP_NL;
				end else if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_ERASE;
					cmd.cnt_sel = CNT_WLEN;
					state_nxt   = S_WRAP_NL;
				end
			end
			S_WRAP_NL: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_NEWLINE;
					cmd.idx_clr = 1'b1;
					state_nxt   = S_COPY_RD;
				end
			end
			// Move the word to the start of the line and echo it.
			S_COPY_RD: begin
				if (sts.pos_full) begin
					cmd.cur_op = CUR_IDX;
					state_nxt  = S_APPEND;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_POS;
					state_nxt  = S_COPY_WR;
				end
			end
			S_COPY_WR: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.act     = ACT_ECHO;
					cmd.ch_sel  = CHS_MEM;
					cmd.wr_copy = 1'b1;
					cmd.idx_inc = 1'b1;
					cmd.pos_op  = POS_INC;
					state_nxt   = S_COPY_RD;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef ASSERT_OFF
	// An accepted keystroke is decoded in the following cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && in_valid) |=> (state_q == S_DECODE))
		else $error("accepted key not decoded");

	// Every run ends with a marked beat before the next key is taken.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == S_IDLE))
		else $error("run ended without returning to idle");

	// The store is never written while a new key is being taken.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!cmd.wr_key && !cmd.wr_copy && !cmd.emit))
		else $error("datapath active while idle");
`endif

endmodule

>>> hw/rtl/line_editor_word_wrap_core.sv
// Top level of the line editor with word wrap: stream ports around controller and datapath.
//
// Each input beat is one raw keystroke byte; the block answers with a run of display
// actions (echo, erase, bell, newline, end of session), the final one marked by m_tlast.
// One keystroke is handled at a time. Simple keys produce a single output beat. Word delete
// and word wrap walk the line store character by character through its single registered
// read port, and a key dropped at a full line with no space gets a bell.
// A stalled m_tready holds the sequence wherever a beat is waiting. The line store needs
// no clearing after reset: only characters below the cursor are ever read.
module line_editor_word_wrap_core
	import lew_pkg::*;
#(
	parameter int unsigned LINE_LEN = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] key_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] action, [10:3] out_char, [16:11] erase_count
	output logic        m_tlast    // last action of the keystroke's run
);

	lew_cmd_t      cmd;
	lew_sts_t      sts;
	logic [2:0]    out_act;
	logic [7:0]    out_char;
	logic [CW-1:0] out_cnt;

	lew_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lew_dp #(
		.LINE_LEN (LINE_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.key_in    (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_act   (out_act),
		.out_char  (out_char),
		.out_cnt   (out_cnt),
		.out_last  (m_tlast)
	);

	// Pack the output beat, padded to whole bytes.
	assign m_tdata = {7'b0, out_cnt, out_char, out_act};

endmodule

>>> verif/testbench.sv
// Self-checking stream testbench for the line editor with word wrap.
module testbench;
	import lew_pkg::*;

	localparam int unsigned LINE_LEN = 40;
	// Queue depth at or below which both sides stop idling for the closing stretch.
	localparam int unsigned QUIET_DEPTH = 30;

	typedef struct {
		act_t       action;
		logic [7:0] ch;
		logic [5:0] count;
		logic       last;
	} disp_action_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] key_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // [2:0] action, [10:3] out_char, [16:11] erase_count
	logic        m_tlast;

	// Keys waiting to be offered, and display actions waiting to be seen.
	logic [7:0]   key_queue[$];
	disp_action_t expected_actions[$];
	disp_action_t run_actions[$];

	// Shadow of the editor state.
	logic [7:0] line_buf[LINE_LEN];
	int         line_cursor;

	int unsigned keys_queued;
	int unsigned keys_taken;
	int unsigned actions_checked;
	int unsigned wraps_seen;
	int unsigned drops_seen;
	int unsigned mismatch_count;

	// Flow control state of the stimulus side and the receiving side.
	bit          key_taken;
	int unsigned send_gap;
	int unsigned rx_stall;
	int unsigned rx_hold;

	line_editor_word_wrap_core #(.LINE_LEN(LINE_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// Append one action to the run being built for the current keystroke.
	function automatic void note_action(act_t a, logic [7:0] c, int n);
		disp_action_t item;
		item.action = a;
		item.ch = c;
		item.count = n[5:0];
		item.last = 1'b0;
		run_actions.push_back(item);
	endfunction

	// Work out the display actions of one keystroke and update the shadow line.
	function automatic void predict_keystroke(logic [7:0] key);
		disp_action_t tail;
		int pos;
		int ws;
		int wlen;
		bit dropped;
		run_actions.delete();
		dropped = 0;
		if (key == KEY_EOF) begin
			note_action(line_cursor == 0 ? ACT_END : ACT_BELL, 8'd0, 0);
		end else if (key == KEY_WERASE) begin
			if (line_cursor == 0) begin
				note_action(ACT_BELL, 8'd0, 0);
			end else begin
				// Trailing spaces go first, then the word before them.
				pos = line_cursor;
				while (pos > 0 && line_buf[pos - 1] == CH_SPACE)
					pos--;
				while (pos > 0 && line_buf[pos - 1] != CH_SPACE)
					pos--;
				note_action(ACT_ERASE, 8'd0, line_cursor - pos);
				line_cursor = pos;
			end
		end else if (key == KEY_BS || key == KEY_DEL) begin
			if (line_cursor == 0) begin
				note_action(ACT_BELL, 8'd0, 0);
			end else begin
				note_action(ACT_ERASE, 8'd0, 1);
				line_cursor--;
			end
		end else if (key == KEY_KILL) begin
			if (line_cursor == 0) begin
				note_action(ACT_BELL, 8'd0, 0);
			end else begin
				note_action(ACT_ERASE, 8'd0, line_cursor);
				line_cursor = 0;
			end
		end else if (key < CH_SPACE || key > CH_TILDE) begin
			note_action(ACT_BELL, 8'd0, 0);
		end else begin
			// A full line wraps its partial last word, or drops the key if there is no space.
			if (line_cursor >= LINE_LEN) begin
				ws = LINE_LEN;
				while (ws > 0 && line_buf[ws - 1] != CH_SPACE)
					ws--;
				if (ws == 0) begin
					note_action(ACT_BELL, 8'd0, 0);
					dropped = 1;
					drops_seen++;
				end else begin
					wlen = LINE_LEN - ws;
					if (wlen > 0)
						note_action(ACT_ERASE, 8'd0, wlen);
					note_action(ACT_NEWLINE, 8'd0, 0);
					for (int i = 0; i < wlen; i++)
						note_action(ACT_ECHO, line_buf[ws + i], 0);
					for (int i = 0; i < wlen; i++)
						line_buf[i] = line_buf[ws + i];
					line_cursor = wlen;
					wraps_seen++;
				end
			end
			if (!dropped) begin
				line_buf[line_cursor] = key;
				line_cursor++;
				note_action(ACT_ECHO, key, 0);
			end
		end
		tail = run_actions.pop_back();
		tail.last = 1'b1;
		run_actions.push_back(tail);
		foreach (run_actions[i])
			expected_actions.push_back(run_actions[i]);
	endfunction

	function automatic void queue_key(logic [7:0] key);
		key_queue.push_back(key);
		keys_queued++;
	endfunction

	function automatic logic [7:0] any_printable();
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	// Words of random length with an occasional edit key in between.
	function automatic void queue_typing(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 19);
			if (r < 3)
				queue_key(CH_SPACE);
			else if (r == 3)
				queue_key($urandom_range(0, 1) ? KEY_BS :
					($urandom_range(0, 1) ? KEY_DEL : KEY_WERASE));
			else
				queue_key(any_printable());
		end
	endfunction

	// Stimulus side: a new beat is offered only once the previous one has gone.
	always @(negedge clk) begin
		if (!s_tvalid || key_taken) begin
			key_taken = 0;
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (key_queue.size() > 0) begin
				s_tdata <= key_queue[0];
				s_tvalid <= 1'b1;
				if (key_queue.size() > QUIET_DEPTH && $urandom_range(0, 11) == 0)
					send_gap = $urandom_range(1, 19);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiving side: a long hold when asked for, short random stalls otherwise.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (key_queue.size() > QUIET_DEPTH && $urandom_range(0, 9) == 0)
				rx_stall = $urandom_range(1, 19);
		end
	end

	// Accepted keys feed the predictor; accepted actions are checked in order.
	always @(posedge clk) begin
		disp_action_t want;
		if (s_tvalid && s_tready) begin
			predict_keystroke(s_tdata);
			void'(key_queue.pop_front());
			keys_taken++;
			key_taken = 1;
		end
		if (m_tvalid && m_tready) begin
			if (expected_actions.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected beat: action %0d char %0d count %0d last %0b",
						m_tdata[2:0], m_tdata[10:3], m_tdata[16:11], m_tlast);
			end else begin
				want = expected_actions.pop_front();
				actions_checked++;
				if (m_tdata[2:0] !== want.action || m_tdata[10:3] !== want.ch ||
						m_tdata[16:11] !== want.count || m_tdata[23:17] !== 7'd0 ||
						m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"Mismatch at beat %0d: expected action %0d char %0d ",
							"count %0d last %0b, got action %0d char %0d count %0d ",
							"last %0b pad %0h"},
							actions_checked, want.action, want.ch, want.count, want.last,
							m_tdata[2:0], m_tdata[10:3], m_tdata[16:11], m_tlast,
							m_tdata[23:17]);
				end
			end
		end
	end

	// Main sequence: directed keys, a stall test, then random editing sessions.
	initial begin
		logic [7:0] directed_keys[$];
		directed_keys = '{KEY_EOF, KEY_BS, KEY_DEL, KEY_KILL, KEY_WERASE, 8'h00, 8'hFF, 8'h80,
			8'h1F, CH_SPACE, CH_TILDE, 8'h61, CH_SPACE, CH_SPACE, KEY_EOF, KEY_WERASE,
			KEY_WERASE, 8'h78, 8'h79, 8'h7A, KEY_BS, KEY_DEL, KEY_KILL};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		m_tready = 1'b0;
		line_cursor = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_keys[i])
			queue_key(directed_keys[i]);

		// Hold the sender until the directed part has fully drained.
		while (key_queue.size() > 0 || expected_actions.size() > 0)
			@(posedge clk);

		// Keep the output blocked for a long stretch while keys keep coming.
		@(posedge clk);
		rx_hold = 400;
		queue_key(KEY_KILL);
		queue_typing(60);

		while (keys_queued < 195) begin
			case ($urandom_range(0, 9))
				5: begin
					// One word as long as the line or longer: bells once full.
					queue_key(KEY_KILL);
					repeat ($urandom_range(40, 44))
						queue_key(any_printable());
				end
				6: begin
					// Full line ending in a space, so the wrap carries no word.
					queue_key(KEY_KILL);
					repeat (39)
						queue_key($urandom_range(0, 4) == 0 ? CH_SPACE : any_printable());
					queue_key(CH_SPACE);
					queue_key(any_printable());
					queue_key(any_printable());
				end
				7: begin
					repeat ($urandom_range(4, 10))
						queue_key(8'($urandom_range(0, 255)));
				end
				8: begin
					queue_key(KEY_KILL);
					queue_key(KEY_EOF);
					queue_key(any_printable());
					queue_key(KEY_EOF);
					queue_key(KEY_BS);
					queue_key(KEY_EOF);
				end
				9: begin
					repeat (6)
						case ($urandom_range(0, 4))
							0: queue_key(KEY_EOF);
							1: queue_key(KEY_BS);
							2: queue_key(KEY_KILL);
							3: queue_key(KEY_WERASE);
							default: queue_key(KEY_DEL);
						endcase
				end
				default: queue_typing($urandom_range(20, 60));
			endcase
		end

		while (key_queue.size() > 0 || expected_actions.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d keystrokes and checked %0d display actions.", keys_taken,
			actions_checked);
		$display("Covered %0d word wraps and %0d keys dropped at a full line.", wraps_seen,
			drops_seen);
		if (mismatch_count == 0 && expected_actions.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d actions never seen.", mismatch_count,
				expected_actions.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#12000000;
		$display("Timeout with %0d keys and %0d actions outstanding.", key_queue.size(),
			expected_actions.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/lew_pkg.sv
hw/rtl/lew_dp.sv
hw/rtl/lew_ctrl.sv
hw/rtl/line_editor_word_wrap_core.sv
verif/testbench.sv
